// ===== hw/rtl/nbnq_pkg.sv =====
`default_nettype none

package nbnq_pkg;

    // Request store geometry and datagram limits.
    localparam int STORE_DEPTH       = 46;
    localparam int STORE_AW          = 6;
    localparam int MIN_REQUEST       = 50;
    localparam int REQUEST_LIMIT_DEF = 96;

    // Response geometry.
    localparam int RESP_IDX_W = 6;
    localparam logic [RESP_IDX_W-1:0] RESP_LAST_IDX = 6'd61;

    // Byte offsets inside the request and the response.
    localparam int OFS_FLAGS_HI  = 2;
    localparam int OFS_QDCOUNT_HI = 4;
    localparam int OFS_QDCOUNT_LO = 5;
    localparam int OFS_NAME_LEN  = 12;
    localparam int OFS_NAME_FIRST = 13;
    localparam int OFS_NAME_LAST  = 44;
    localparam int NAME_CHARS    = 15;

    // Fixed byte values.
    localparam logic [7:0] RESP_FLAGS_HI = 8'h85;
    localparam logic [7:0] NAME_LEN_BYTE = 8'h20;
    localparam logic [7:0] SPACE_CHAR    = 8'h20;
    localparam logic [7:0] CHAR_A        = 8'h41;
    localparam logic [7:0] CHAR_P        = 8'h50;
    localparam logic [7:0] ANCOUNT_LO    = 8'h01;
    localparam logic [7:0] TYPE_NB_LO    = 8'h20;
    localparam logic [7:0] CLASS_IN_LO   = 8'h01;
    localparam logic [7:0] RDLENGTH_LO   = 8'h06;
    localparam logic [15:0] TTL_RESET    = 16'd300;

    // Configuration register indexes (byte address / 8).
    localparam logic [2:0] REG_HOST_LEN   = 3'd0;
    localparam logic [2:0] REG_CHARS_LOW  = 3'd1;
    localparam logic [2:0] REG_CHARS_HIGH = 3'd2;
    localparam logic [2:0] REG_OWN_IP     = 3'd3;
    localparam logic [2:0] REG_TTL        = 3'd4;

    typedef struct packed {
        logic [5:0]  host_len;
        logic [63:0] host_chars_low;
        logic [55:0] host_chars_high;
        logic [31:0] own_ip;
        logic [15:0] answer_ttl;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;     // an input beat is accepted
        logic decide;   // datagram closed: evaluate and rewind
        logic advance;  // a response beat is accepted
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic answer;
        logic final_beat;
    } dp_status_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        upcase = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    // Hostname character at a position; position 15 reads as zero.
    function automatic logic [7:0] host_char(input cfg_t cfg, input logic [3:0] pos);
        logic [63:0] lo_sh;
        logic [55:0] hi_sh;
        lo_sh = cfg.host_chars_low >> {pos[2:0], 3'b000};
        hi_sh = cfg.host_chars_high >> {pos[2:0], 3'b000};
        if (!pos[3]) begin
            host_char = lo_sh[7:0];
        end else if (pos != 4'hF) begin
            host_char = hi_sh[7:0];
        end else begin
            host_char = 8'h00;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nbnq_ctrl.sv =====
`default_nettype none

module nbnq_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    input  wire                    s_tlast,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    input  nbnq_pkg::dp_status_t   status,
    output nbnq_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_RECV   = 3'b001,
        ST_DECIDE = 3'b010,
        ST_SEND   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Handshakes and commands follow the state directly.
    always_comb begin
        s_tready    = (state_reg == ST_RECV);
        m_tvalid    = (state_reg == ST_SEND);
        cmd.take    = s_tready && s_tvalid;
        cmd.decide  = (state_reg == ST_DECIDE);
        cmd.advance = m_tvalid && m_tready;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RECV: begin
                if (cmd.take && s_tlast) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = status.answer ? ST_SEND : ST_RECV;
            end
            ST_SEND: begin
                if (cmd.advance && status.final_beat) state_next = ST_RECV;
            end
            default: state_next = ST_RECV;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RECV;
        end else begin
            state_reg <= state_next;
        end
    end

    // The input and output sides never handshake in the same cycle.
    a_sides_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    // The cycle after a last input beat is the decision cycle: both sides closed.
    a_decide_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take && s_tlast) |=> (!s_tready && !m_tvalid))
        else $error("no decision cycle after last beat");

    // A rejected datagram reopens the input at once.
    a_reject_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.decide && !status.answer) |=> s_tready)
        else $error("input not reopened after rejected datagram");

    // The final response beat reopens the input.
    a_final_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.advance && status.final_beat) |=> (s_tready && !m_tvalid))
        else $error("input not reopened after response");

endmodule

`default_nettype wire

// ===== hw/rtl/nbnq_dp.sv =====
`default_nettype none

module nbnq_dp #(
    parameter int REQUEST_LIMIT = nbnq_pkg::REQUEST_LIMIT_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  nbnq_pkg::cfg_t         cfg,
    input  nbnq_pkg::ctrl_cmd_t    cmd,
    input  wire [7:0]              s_data,
    output nbnq_pkg::dp_status_t   status,
    output logic [7:0]             m_data,
    output logic                   m_last
);

    localparam int CNT_W = $clog2(REQUEST_LIMIT + 1);
    localparam int AW    = nbnq_pkg::STORE_AW;
    localparam int RW    = nbnq_pkg::RESP_IDX_W;

    logic [7:0]     store_mem [nbnq_pkg::STORE_DEPTH];
    logic [7:0]     rd_data_reg;
    logic [AW-1:0]  rd_addr;
    logic [CNT_W-1:0] byte_count_reg;
    logic           still_valid_reg;
    logic           name_matches_reg;
    logic [3:0]     high_nibble_reg;
    logic           qd_nonzero_reg;
    logic [RW-1:0]  out_idx_reg;

    logic           in_store;
    logic           in_name;
    logic           char_ok;
    logic [3:0]     nib;
    logic [4:0]     name_k;
    logic [3:0]     pos;
    logic [7:0]     decoded;
    logic           pair_mismatch;
    logic           hdr_bad;
    logic [3:0]     last_pos;

    // Position decode of the current input byte.
    always_comb begin
        in_store = byte_count_reg < CNT_W'(nbnq_pkg::STORE_DEPTH);
        in_name  = byte_count_reg >= CNT_W'(nbnq_pkg::OFS_NAME_FIRST)
                && byte_count_reg <= CNT_W'(nbnq_pkg::OFS_NAME_LAST);
        name_k   = 5'(byte_count_reg - CNT_W'(nbnq_pkg::OFS_NAME_FIRST));
        pos      = name_k[4:1];
        nib      = 4'(s_data - nbnq_pkg::CHAR_A);
        char_ok  = s_data >= nbnq_pkg::CHAR_A && s_data <= nbnq_pkg::CHAR_P;
        decoded  = {high_nibble_reg, nib};
    end

    // Header, length byte and character checks.
    always_comb begin
        hdr_bad = 1'b0;
        if (byte_count_reg == CNT_W'(nbnq_pkg::OFS_FLAGS_HI)) begin
            hdr_bad = s_data[7] || (s_data[6:3] != 4'h0);
        end else if (byte_count_reg == CNT_W'(nbnq_pkg::OFS_NAME_LEN)) begin
            hdr_bad = s_data != nbnq_pkg::NAME_LEN_BYTE;
        end else if (in_name) begin
            hdr_bad = !char_ok;
        end
    end

    // Decoded byte against the hostname, or a space past its length, on the second half of each pair but the last.
    always_comb begin
        pair_mismatch = 1'b0;
        if (in_name && name_k[0] && pos != 4'(nbnq_pkg::NAME_CHARS)) begin
            if ({2'b00, pos} < cfg.host_len) begin
                pair_mismatch = nbnq_pkg::upcase(decoded)
                             != nbnq_pkg::upcase(nbnq_pkg::host_char(cfg, pos));
            end else begin
                pair_mismatch = decoded != nbnq_pkg::SPACE_CHAR;
            end
        end
    end

    // Per-datagram tracking state, rewound on the decision cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.decide) begin
            byte_count_reg   <= '0;
            still_valid_reg  <= 1'b1;
            name_matches_reg <= 1'b1;
            high_nibble_reg  <= 4'h0;
        end else if (cmd.take) begin
            if (byte_count_reg < CNT_W'(REQUEST_LIMIT)) begin
                byte_count_reg <= byte_count_reg + 1'b1;
            end
            if (hdr_bad) still_valid_reg <= 1'b0;
            if (pair_mismatch) name_matches_reg <= 1'b0;
            if (in_name && !name_k[0]) high_nibble_reg <= nib;
        end
    end

    // The question count is nonzero if either of its bytes is.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            if (byte_count_reg == CNT_W'(nbnq_pkg::OFS_QDCOUNT_HI)) begin
                qd_nonzero_reg <= s_data != 8'h00;
            end else if (byte_count_reg == CNT_W'(nbnq_pkg::OFS_QDCOUNT_LO)) begin
                qd_nonzero_reg <= qd_nonzero_reg || (s_data != 8'h00);
            end
        end
    end

    // Request store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.take && in_store) begin
            store_mem[byte_count_reg[AW-1:0]] <= s_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Read address leads the response index by one beat on each advance.
    always_comb begin
        logic [RW-1:0] want;
        want = cmd.decide  ? '0 :
               cmd.advance ? out_idx_reg + 1'b1 : out_idx_reg;
        rd_addr = (want < RW'(nbnq_pkg::STORE_DEPTH)) ? want[AW-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.decide) begin
            out_idx_reg <= '0;
        end else if (cmd.advance) begin
            out_idx_reg <= out_idx_reg + 1'b1;
        end
    end

    // Answer decision on the closed datagram.
    always_comb begin
        last_pos      = 4'(cfg.host_len - 6'd1);
        status.answer = byte_count_reg >= CNT_W'(nbnq_pkg::MIN_REQUEST)
                     && still_valid_reg && name_matches_reg && qd_nonzero_reg
                     && cfg.host_len != 6'd0
                     && cfg.host_len <= 6'(nbnq_pkg::NAME_CHARS)
                     && nbnq_pkg::host_char(cfg, last_pos) != nbnq_pkg::SPACE_CHAR
                     && cfg.own_ip != 32'h0;
        status.final_beat = out_idx_reg == nbnq_pkg::RESP_LAST_IDX;
    end

    // Response byte for the current index.
    always_comb begin
        case (out_idx_reg)
            6'd0, 6'd1:  m_data = rd_data_reg;
            6'd2:        m_data = nbnq_pkg::RESP_FLAGS_HI;
            6'd7:        m_data = nbnq_pkg::ANCOUNT_LO;
            6'd47:       m_data = nbnq_pkg::TYPE_NB_LO;
            6'd49:       m_data = nbnq_pkg::CLASS_IN_LO;
            6'd52:       m_data = cfg.answer_ttl[15:8];
            6'd53:       m_data = cfg.answer_ttl[7:0];
            6'd55:       m_data = nbnq_pkg::RDLENGTH_LO;
            6'd58:       m_data = cfg.own_ip[31:24];
            6'd59:       m_data = cfg.own_ip[23:16];
            6'd60:       m_data = cfg.own_ip[15:8];
            6'd61:       m_data = cfg.own_ip[7:0];
            default: begin
                if (out_idx_reg inside {[6'd12:6'd45]}) begin
                    m_data = rd_data_reg;
                end else begin
                    m_data = 8'h00;
                end
            end
        endcase
        m_last = status.final_beat;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/netbios_name_query_responder_top.sv =====
// After the last payload beat the decision state comes before the first response beat.
// Throughput: one payload beat per cycle while s_tready is high; a response runs one beat
// per cycle for 62 beats while m_tready is high. The input is held off after the last
// payload beat through the decision state and, if answered, until the response is drained.
// Reset: synchronous, active-low aresetn; the store, read data and qd flag do not reset.
`default_nettype none

module netbios_name_query_responder_top #(
    parameter int REQUEST_LIMIT = nbnq_pkg::REQUEST_LIMIT_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [5:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Payload input.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_in
    input  wire         s_tlast,
    // Response output.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out
    output logic        m_tlast
);

    nbnq_pkg::cfg_t       cfg_reg;
    nbnq_pkg::ctrl_cmd_t  cmd;
    nbnq_pkg::dp_status_t status;
    logic                 cfg_write;
    logic [2:0]           reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.host_len        <= '0;
            cfg_reg.host_chars_low  <= '0;
            cfg_reg.host_chars_high <= '0;
            cfg_reg.own_ip          <= '0;
            cfg_reg.answer_ttl      <= nbnq_pkg::TTL_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                nbnq_pkg::REG_HOST_LEN:   cfg_reg.host_len        <= pwdata[5:0];
                nbnq_pkg::REG_CHARS_LOW:  cfg_reg.host_chars_low  <= pwdata;
                nbnq_pkg::REG_CHARS_HIGH: cfg_reg.host_chars_high <= pwdata[55:0];
                nbnq_pkg::REG_OWN_IP:     cfg_reg.own_ip          <= pwdata[31:0];
                nbnq_pkg::REG_TTL:        cfg_reg.answer_ttl      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (reg_idx)
            nbnq_pkg::REG_HOST_LEN:   prdata = {58'b0, cfg_reg.host_len};
            nbnq_pkg::REG_CHARS_LOW:  prdata = cfg_reg.host_chars_low;
            nbnq_pkg::REG_CHARS_HIGH: prdata = {8'b0, cfg_reg.host_chars_high};
            nbnq_pkg::REG_OWN_IP:     prdata = {32'b0, cfg_reg.own_ip};
            nbnq_pkg::REG_TTL:        prdata = {48'b0, cfg_reg.answer_ttl};
            default:                  prdata = '0;
        endcase
    end

    nbnq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nbnq_dp #(
        .REQUEST_LIMIT (REQUEST_LIMIT)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .s_data  (s_tdata),
        .status  (status),
        .m_data  (m_tdata),
        .m_last  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RESP_BYTES   = 62;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] LOWER_A  = 8'h61;
    localparam logic [7:0] LOWER_Z  = 8'h7A;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } resp_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    netbios_name_query_responder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Configuration as the block should hold it.
    logic [5:0]  cfg_host_len;
    logic [63:0] cfg_chars_low;
    logic [55:0] cfg_chars_high;
    logic [31:0] cfg_own_ip;
    logic [15:0] cfg_ttl;

    // Per-datagram parse state of the predicted responder.
    logic [7:0]  query_store [0:nbnq_pkg::STORE_DEPTH-1];
    int          query_count;
    logic        query_ok;
    logic [3:0]  query_hi_nib;
    logic        query_name_ok;

    resp_beat_t  answer_q [$];
    resp_beat_t  answer_head;
    logic [7:0]  pkt [$];

    int src_idle_pct;
    int sink_idle_pct;
    int sink_hold;
    int cycle_count;
    int errors;
    int beats_in;
    int beats_out;
    int dgrams_sent;
    int answers_predicted;

    // Clock: 8 ns period.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic logic [7:0] host_byte(input int pos);
        if (pos < 8) begin
            return cfg_chars_low[8*pos +: 8];
        end
        if (pos < nbnq_pkg::NAME_CHARS) begin
            return cfg_chars_high[8*(pos-8) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= LOWER_A && c <= LOWER_Z) ? c - CASE_BIT : c;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= nbnq_pkg::CHAR_A && c <= UPPER_Z) || (c >= LOWER_A && c <= LOWER_Z);
    endfunction

    task automatic clear_query_state();
        query_count   = 0;
        query_ok      = 1'b1;
        query_hi_nib  = 4'h0;
        query_name_ok = 1'b1;
    endtask

    // Follows one accepted payload byte and queues the answer it triggers.
    task automatic track_query_byte(input logic [7:0] b, input logic last);
        int         idx;
        int         k;
        int         pos;
        logic [7:0] diff;
        logic [7:0] dec;
        logic [7:0] resp [0:RESP_BYTES-1];
        bit         answer;

        idx = query_count;
        if (idx < nbnq_pkg::STORE_DEPTH) begin
            query_store[idx] = b;
        end

        // Header and name checks as the bytes go by.
        if (idx == nbnq_pkg::OFS_FLAGS_HI) begin
            if (b[7] || b[6:3] != 4'h0) begin
                query_ok = 1'b0;
            end
        end else if (idx == nbnq_pkg::OFS_NAME_LEN) begin
            if (b != nbnq_pkg::NAME_LEN_BYTE) begin
                query_ok = 1'b0;
            end
        end else if (idx >= nbnq_pkg::OFS_NAME_FIRST && idx <= nbnq_pkg::OFS_NAME_LAST) begin
            k = idx - nbnq_pkg::OFS_NAME_FIRST;
            diff = b - nbnq_pkg::CHAR_A;
            if (b < nbnq_pkg::CHAR_A || b > nbnq_pkg::CHAR_P) begin
                query_ok = 1'b0;
            end
            if (k % 2 == 0) begin
                query_hi_nib = diff[3:0];
            end else begin
                pos = k / 2;
                dec = {query_hi_nib, diff[3:0]};
                // The sixteenth decoded byte is the suffix and is not compared.
                if (pos < nbnq_pkg::NAME_CHARS) begin
                    if (pos < int'(cfg_host_len)) begin
                        if (fold_case(dec) != fold_case(host_byte(pos))) begin
                            query_name_ok = 1'b0;
                        end
                    end else if (dec != nbnq_pkg::SPACE_CHAR) begin
                        query_name_ok = 1'b0;
                    end
                end
            end
        end
        if (query_count < nbnq_pkg::REQUEST_LIMIT_DEF) begin
            query_count++;
        end

        if (!last) begin
            return;
        end

        answer = query_count >= nbnq_pkg::MIN_REQUEST && query_ok && query_name_ok
              && (query_store[nbnq_pkg::OFS_QDCOUNT_HI]
                  | query_store[nbnq_pkg::OFS_QDCOUNT_LO]) != 8'h00
              && cfg_host_len != 6'd0 && cfg_host_len <= 6'd15
              && host_byte(int'(cfg_host_len) - 1) != nbnq_pkg::SPACE_CHAR
              && cfg_own_ip != 32'h0;

        if (answer) begin
            for (int i = 0; i < RESP_BYTES; i++) begin
                resp[i] = 8'h00;
            end
            resp[0] = query_store[0];
            resp[1] = query_store[1];
            resp[2] = nbnq_pkg::RESP_FLAGS_HI;
            resp[7] = nbnq_pkg::ANCOUNT_LO;
            for (int i = 0; i < 34; i++) begin
                resp[nbnq_pkg::OFS_NAME_LEN + i] = query_store[nbnq_pkg::OFS_NAME_LEN + i];
            end
            resp[47] = nbnq_pkg::TYPE_NB_LO;
            resp[49] = nbnq_pkg::CLASS_IN_LO;
            resp[52] = cfg_ttl[15:8];
            resp[53] = cfg_ttl[7:0];
            resp[55] = nbnq_pkg::RDLENGTH_LO;
            resp[58] = cfg_own_ip[31:24];
            resp[59] = cfg_own_ip[23:16];
            resp[60] = cfg_own_ip[15:8];
            resp[61] = cfg_own_ip[7:0];
            for (int i = 0; i < RESP_BYTES; i++) begin
                answer_q.push_back('{data: resp[i], last: (i == RESP_BYTES - 1)});
            end
            answers_predicted++;
        end
        clear_query_state();
    endtask

    // Two-phase register write; the block takes it at the access edge.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            nbnq_pkg::REG_HOST_LEN:   cfg_host_len   = value[5:0];
            nbnq_pkg::REG_CHARS_LOW:  cfg_chars_low  = value;
            nbnq_pkg::REG_CHARS_HIGH: cfg_chars_high = value[55:0];
            nbnq_pkg::REG_OWN_IP:     cfg_own_ip     = value[31:0];
            nbnq_pkg::REG_TTL:        cfg_ttl        = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_host(input string name, input int len);
        logic [63:0] lo;
        logic [55:0] hi;

        lo = '0;
        hi = '0;
        for (int i = 0; i < name.len() && i < nbnq_pkg::NAME_CHARS; i++) begin
            if (i < 8) begin
                lo[8*i +: 8] = name[i];
            end else begin
                hi[8*(i-8) +: 8] = name[i];
            end
        end
        write_reg(nbnq_pkg::REG_CHARS_LOW, lo);
        write_reg(nbnq_pkg::REG_CHARS_HIGH, {8'h00, hi});
        write_reg(nbnq_pkg::REG_HOST_LEN, 64'(len));
    endtask

    // Sends one payload beat, with an occasional gap in front of it.
    task automatic send_beat(input logic [7:0] b, input logic last);
        @(negedge aclk);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        track_query_byte(b, last);
        beats_in++;
    endtask

    task automatic send_datagram();
        for (int i = 0; i < pkt.size(); i++) begin
            send_beat(pkt[i], i == pkt.size() - 1);
        end
        dgrams_sent++;
    endtask

    // Drops valid and waits until every predicted answer has come out.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Well-formed query for the configured hostname, random header and case.
    task automatic build_query(input int extra);
        logic [7:0] c;
        logic [7:0] b;
        int         n;

        pkt.delete();
        for (int i = 0; i < 12; i++) begin
            pkt.push_back(8'($urandom));
        end
        b = 8'($urandom);
        b[7:3] = 5'b00000;
        pkt[nbnq_pkg::OFS_FLAGS_HI] = b;
        if ((pkt[nbnq_pkg::OFS_QDCOUNT_HI] | pkt[nbnq_pkg::OFS_QDCOUNT_LO]) == 8'h00) begin
            pkt[nbnq_pkg::OFS_QDCOUNT_LO] = 8'h01;
        end
        pkt.push_back(nbnq_pkg::NAME_LEN_BYTE);
        n = (cfg_host_len > 6'd15) ? nbnq_pkg::NAME_CHARS : int'(cfg_host_len);
        for (int i = 0; i <= nbnq_pkg::NAME_CHARS; i++) begin
            if (i < n) begin
                c = host_byte(i);
                if (is_letter(c) && $urandom_range(1) == 1) begin
                    c = c ^ CASE_BIT;
                end
            end else if (i < nbnq_pkg::NAME_CHARS) begin
                c = nbnq_pkg::SPACE_CHAR;
            end else begin
                c = 8'($urandom);
            end
            pkt.push_back(nbnq_pkg::CHAR_A + {4'h0, c[7:4]});
            pkt.push_back(nbnq_pkg::CHAR_A + {4'h0, c[3:0]});
        end
        // Root label, then question type NB and class IN.
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(nbnq_pkg::TYPE_NB_LO);
        pkt.push_back(8'h00);
        pkt.push_back(nbnq_pkg::CLASS_IN_LO);
        repeat (extra) pkt.push_back(8'($urandom));
    endtask

    // Random bytes, too short to be answered.
    task automatic build_noise(input int len);
        pkt.delete();
        repeat (len) pkt.push_back(8'($urandom));
    endtask

    // Response side: random stalls, plus a long hold-off when a test asks.
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold--;
        end else begin
            m_tready <= !(sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct);
        end
    end

    // Compare every response beat with the oldest predicted one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: response beat with none expected: data %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                answer_head = answer_q.pop_front();
                if (m_tdata !== answer_head.data) begin
                    $display("%0t: response data mismatch: expected %h actual %h",
                             $time, answer_head.data, m_tdata);
                    errors++;
                end
                if (m_tlast !== answer_head.last) begin
                    $display("%0t: response last mismatch: expected %b actual %b",
                             $time, answer_head.last, m_tlast);
                    errors++;
                end
                beats_out++;
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    // Reset values only: host length zero keeps the block silent.
    task automatic test_disabled_after_reset();
        build_query(0);
        send_datagram();
        wait_drained();
    endtask

    // First answer, with the TTL still at its reset value.
    task automatic test_first_answer();
        set_host("nbHost-1", 8);
        write_reg(nbnq_pkg::REG_OWN_IP, 64'hC0A8_0A05);
        build_query(0);
        send_datagram();
        wait_drained();
        write_reg(nbnq_pkg::REG_TTL, 64'd3600);
    endtask

    // Payloads below the minimum length are never answered.
    task automatic test_short_payloads();
        build_query(0);
        while (pkt.size() > 10) begin
            void'(pkt.pop_back());
        end
        send_datagram();
        // Single-byte datagram.
        pkt.delete();
        pkt.push_back(8'hFF);
        send_datagram();
        wait_drained();
    endtask

    // The receiver holds off while the next datagram is offered, so the input
    // stalls; then both sides run without idling.
    task automatic test_output_hold();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        sink_hold = HOLD_CYCLES;
        build_query(2);
        send_datagram();
        build_noise(6);
        send_datagram();
        wait_drained();
        src_idle_pct = 20;
        sink_idle_pct = 20;
    endtask

    initial begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        aresetn = 1'b0;
        src_idle_pct = 20;
        sink_idle_pct = 20;
        sink_hold = 0;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        dgrams_sent = 0;
        answers_predicted = 0;
        cfg_host_len = 6'd0;
        cfg_chars_low = '0;
        cfg_chars_high = '0;
        cfg_own_ip = '0;
        cfg_ttl = nbnq_pkg::TTL_RESET;
        for (int i = 0; i < nbnq_pkg::STORE_DEPTH; i++) begin
            query_store[i] = 8'h00;
        end
        clear_query_state();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_disabled_after_reset();
        test_first_answer();
        test_short_payloads();
        test_output_hold();

        $display("Sent %0d datagrams (%0d payload beats); %0d answers predicted,",
                 dgrams_sent, beats_in, answers_predicted);
        $display("%0d response beats checked, %0d mismatches.", beats_out, errors);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
